### rtl/ascii_to_int64_parser_defines.svh
// ============================================================================
// ascii_to_int64_parser assertion macros
// Concurrent assertion wrappers that fall away when SYNTH is defined.
// ============================================================================
`ifndef ASCII_TO_INT64_PARSER_DEFINES_SVH
`define ASCII_TO_INT64_PARSER_DEFINES_SVH

`ifndef SYNTH
// Checks a property on every clock edge outside reset.
`define A2I_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("a2i assertion failed");
// Checks a property on every clock edge, reset included.
`define A2I_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("a2i assertion failed");
`else
`define A2I_ASSERT(name, prop)
`define A2I_ASSERT_ALWAYS(name, prop)
`endif

`endif

### rtl/a2i_pkg.sv
// ============================================================================
// a2i_pkg
// Types, codes and character constants of the ASCII to int64 parser.
// ============================================================================
package a2i_pkg;

    localparam logic [7:0] MAX_WINDOW = 8'd255;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] UP_LETTER_BIAS = CHAR_UP_A - 8'd10;
    localparam logic [7:0] LO_LETTER_BIAS = CHAR_LO_A - 8'd10;
    localparam logic [7:0] DIGIT_NONE = 8'd255;

    localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    localparam logic [5:0] BASE_AUTO    = 6'd0;
    localparam logic [5:0] BASE_OCTAL   = 6'd8;
    localparam logic [5:0] BASE_DECIMAL = 6'd10;
    localparam logic [5:0] BASE_HEX     = 6'd16;

    localparam logic [1:0] REG_NUMBER_BASE  = 2'd0;
    localparam logic [1:0] REG_SIGN_ALLOWED = 2'd1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_VALUE = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_BASE   = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_OK   = 2'd1,
        DS_OVER = 2'd2
    } digit_status_t;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = c - CHAR_ZERO;
        end
        else if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
        begin
            d = c - UP_LETTER_BIAS;
        end
        else if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
        begin
            d = c - LO_LETTER_BIAS;
        end
        else
        begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

endpackage

### rtl/ascii_to_int64_parser.sv
// ============================================================================
// ascii_to_int64_parser
// Converts a window of ASCII bytes to a signed 64-bit integer in the manner
// of strtoll, with optional sign, base detection and overflow reporting.
// ============================================================================
//
// Channel  Handshake            Payload                    Direction
// -------  -------------------  -------------------------  ---------
// in       in_valid/in_ready    char_byte, window_end      into block
// out      out_valid/out_ready  status, value, consumed    out of block
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data        into block
//
// Each byte is registered, then folded into the window state by one
// multiply-accumulate with the base; one item per cycle while the input is not stalled.
// The result of a window is loaded into the result register when its last byte leaves the byte register.
// A last byte waits while the result register holds an item not yet taken,
// and the input stalls behind it. The configuration port is always ready.
// Reset clears the window state and selects automatic base detection with signs accepted.
`include "ascii_to_int64_parser_defines.svh"

module ascii_to_int64_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_byte,
    input  logic               window_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [63:0] value,
    output logic [7:0]         consumed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data
);

    logic [5:0] number_base_reg;
    logic       sign_allowed_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       s1_adv;

    a2i_pkg::phase_t        phase_reg, phase_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [5:0]             base_reg, base_next;
    a2i_pkg::digit_status_t ds_reg, ds_next;
    logic [7:0]             count_reg, count_next;
    logic                   stopped_reg, stopped_next;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [63:0] out_mag_reg;
    logic        out_neg_reg;
    logic [7:0]  out_count_reg;

    logic [1:0]  res_status;
    logic [63:0] res_mag;
    logic        res_neg;
    logic [7:0]  res_count;

    logic        take;
    logic        is_sign;
    logic        auto_zero;
    logic        choose;
    logic        do_digit;
    logic [5:0]  picked_base;
    logic [5:0]  digit_base;
    logic [7:0]  dig;
    logic [63:0] limit;
    logic [69:0] prod;
    logic        ovf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg  <= a2i_pkg::BASE_AUTO;
            sign_allowed_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                a2i_pkg::REG_NUMBER_BASE:  number_base_reg  <= cfg_data;
                a2i_pkg::REG_SIGN_ALLOWED: sign_allowed_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s1_adv   = s1_valid_reg && (!s1_end_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= char_byte;
            s1_end_reg  <= window_end;
        end
    end

    assign take      = !stopped_reg && (count_reg < a2i_pkg::MAX_WINDOW);
    assign is_sign   = sign_allowed_reg &&
                       (s1_byte_reg == a2i_pkg::CHAR_MINUS ||
                        s1_byte_reg == a2i_pkg::CHAR_PLUS);
    assign auto_zero = (number_base_reg == a2i_pkg::BASE_AUTO ||
                        number_base_reg == a2i_pkg::BASE_HEX) &&
                       s1_byte_reg == a2i_pkg::CHAR_ZERO;
    assign picked_base = (number_base_reg == a2i_pkg::BASE_AUTO) ?
                         a2i_pkg::BASE_DECIMAL : number_base_reg;
    assign digit_base = (phase_reg == a2i_pkg::PH_START ||
                         phase_reg == a2i_pkg::PH_BASE) ? picked_base : base_reg;
    assign dig   = a2i_pkg::digit_value(s1_byte_reg);
    assign limit = neg_reg ? a2i_pkg::VALUE_MIN : a2i_pkg::VALUE_MAX;
    // The product stays exact in 70 bits, so comparing it with the limit
    // gives the same answer as the per-base cutoff test.
    assign prod  = 70'(acc_reg) * 70'(digit_base) + 70'(dig);
    assign ovf   = prod > 70'(limit);

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        base_next    = base_reg;
        ds_next      = ds_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        choose       = 1'b0;
        do_digit     = 1'b0;

        if (take)
        begin
            unique case (phase_reg)
                a2i_pkg::PH_START:
                begin
                    if (is_sign)
                    begin
                        neg_next   = (s1_byte_reg == a2i_pkg::CHAR_MINUS);
                        count_next = count_reg + 8'd1;
                        phase_next = a2i_pkg::PH_BASE;
                    end
                    else
                    begin
                        choose = 1'b1;
                    end
                end
                a2i_pkg::PH_BASE:
                begin
                    choose = 1'b1;
                end
                a2i_pkg::PH_ZERO:
                begin
                    phase_next = a2i_pkg::PH_DIGITS;
                    if (s1_byte_reg == a2i_pkg::CHAR_LO_X ||
                        s1_byte_reg == a2i_pkg::CHAR_UP_X)
                    begin
                        base_next  = a2i_pkg::BASE_HEX;
                        ds_next    = a2i_pkg::DS_NONE;
                        count_next = count_reg + 8'd1;
                    end
                    else
                    begin
                        do_digit = 1'b1;
                    end
                end
                a2i_pkg::PH_DIGITS:
                begin
                    do_digit = 1'b1;
                end
                default: ;
            endcase

            if (choose)
            begin
                if (auto_zero)
                begin
                    base_next  = (number_base_reg == a2i_pkg::BASE_HEX) ?
                                 a2i_pkg::BASE_HEX : a2i_pkg::BASE_OCTAL;
                    ds_next    = a2i_pkg::DS_OK;
                    acc_next   = '0;
                    count_next = count_reg + 8'd1;
                    phase_next = a2i_pkg::PH_ZERO;
                end
                else
                begin
                    base_next  = picked_base;
                    phase_next = a2i_pkg::PH_DIGITS;
                    do_digit   = 1'b1;
                end
            end

            if (do_digit)
            begin
                if (dig >= {2'b00, digit_base})
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    if (ds_reg == a2i_pkg::DS_OVER || ovf)
                    begin
                        ds_next = a2i_pkg::DS_OVER;
                    end
                    else
                    begin
                        ds_next  = a2i_pkg::DS_OK;
                        acc_next = prod[63:0];
                    end
                    count_next = count_reg + 8'd1;
                end
            end
        end

        if (count_next >= a2i_pkg::MAX_WINDOW)
        begin
            stopped_next = 1'b1;
        end
    end

    always_comb
    begin
        res_status = a2i_pkg::STATUS_NO_VALUE;
        res_mag    = '0;
        res_neg    = 1'b0;
        res_count  = '0;
        if (phase_next == a2i_pkg::PH_ZERO || phase_next == a2i_pkg::PH_DIGITS)
        begin
            if (ds_next == a2i_pkg::DS_OK)
            begin
                res_status = a2i_pkg::STATUS_OK;
                res_mag    = acc_next;
                res_neg    = neg_next;
                res_count  = count_next;
            end
            else if (ds_next == a2i_pkg::DS_OVER)
            begin
                res_status = a2i_pkg::STATUS_OVERFLOW;
                res_mag    = neg_next ? a2i_pkg::VALUE_MIN : a2i_pkg::VALUE_MAX;
                res_neg    = neg_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= a2i_pkg::PH_START;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            base_reg    <= '0;
            ds_reg      <= a2i_pkg::DS_NONE;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_end_reg)
            begin
                phase_reg   <= a2i_pkg::PH_START;
                acc_reg     <= '0;
                neg_reg     <= 1'b0;
                base_reg    <= '0;
                ds_reg      <= a2i_pkg::DS_NONE;
                count_reg   <= '0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                base_reg    <= base_next;
                ds_reg      <= ds_next;
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_end_reg)
        begin
            out_status_reg <= res_status;
            out_mag_reg    <= res_mag;
            out_neg_reg    <= res_neg;
            out_count_reg  <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign consumed  = out_count_reg;
    assign value     = out_neg_reg ? (~out_mag_reg + 64'd1) : out_mag_reg;

    `A2I_ASSERT(a_consumed_only_ok,
        out_valid |-> (status == a2i_pkg::STATUS_OK) || (consumed == 8'd0))
    `A2I_ASSERT(a_overflow_saturates,
        (out_valid && status == a2i_pkg::STATUS_OVERFLOW) |->
            (value == a2i_pkg::VALUE_MAX) || (value == a2i_pkg::VALUE_MIN))
    `A2I_ASSERT(a_window_cleared,
        (s1_adv && s1_end_reg) |=>
            (phase_reg == a2i_pkg::PH_START) && (count_reg == 8'd0) && !stopped_reg)
    `A2I_ASSERT(a_stall_only_on_full_result,
        !in_ready |-> out_valid && !out_ready && s1_end_reg)

endmodule
